### rtl/shell_command_line_tokenizer_assert.svh
// Assertion macros shared by the tokenizer modules.
// SCLT_ASSERT checks on every clock edge outside reset.
// SCLT_ASSERT_ALWAYS checks on every clock edge, reset included.
`ifndef SHELL_COMMAND_LINE_TOKENIZER_ASSERT_SVH
`define SHELL_COMMAND_LINE_TOKENIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define SCLT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCLT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCLT_ASSERT(label, prop, msg)
`define SCLT_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

### rtl/sclt_pkg.sv
`timescale 1ns / 1ps

package sclt_pkg;

    // Longest line in bytes; positions and counts stop at the cap
    localparam int MAX_LINE = 4096;
    localparam int POS_W    = 13;
    localparam logic [POS_W-1:0] POS_CAP =
        POS_W'((MAX_LINE < 8191) ? MAX_LINE : 8191);

    // Result queue sizing
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // Byte codes
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_PIPE   = 8'h7C;

    typedef enum logic [2:0] {
        K_WORD    = 3'd0,
        K_QUOTED  = 3'd1,
        K_IN      = 3'd2,
        K_OUT     = 3'd3,
        K_HEREDOC = 3'd4,
        K_APPEND  = 3'd5,
        K_PIPE    = 3'd6,
        K_END     = 3'd7
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        kind_t            kind;
        logic [POS_W-1:0] start_pos;
        logic [POS_W-1:0] end_pos;
        logic [POS_W-1:0] token_count;
        logic             last;
    } result_t;

    // Up to two results from one byte; v1 only together with v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } push_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
        return (v >= POS_CAP) ? POS_CAP : v + POS_W'(1);
    endfunction

endpackage

### rtl/sclt_lexer.sv
`timescale 1ns / 1ps

module sclt_lexer
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  sclt_pkg::in_item_t item,
    output sclt_pkg::push_t   push,
    output logic              busy
);
    import sclt_pkg::*;

`include "shell_command_line_tokenizer_assert.svh"

    // Input register
    logic       in_valid_reg;
    logic [7:0] ch_reg;
    logic       eol_reg;

    // Line state
    logic             word_active_reg, word_active_next;
    logic             quote_active_reg, quote_active_next;
    logic             quote_is_double_reg, quote_is_double_next;
    logic             redirect_pending_reg, redirect_pending_next;
    logic             redirect_is_output_reg, redirect_is_output_next;
    logic [POS_W-1:0] position_reg, position_next;
    logic [POS_W-1:0] word_start_reg, word_start_next;
    logic [POS_W-1:0] quote_start_reg, quote_start_next;
    logic [POS_W-1:0] redirect_start_reg, redirect_start_next;
    logic [POS_W-1:0] tokens_seen_reg, tokens_seen_next;

    // Token emitted before the byte's own token, and the byte's own token
    logic             pre_v, main_v, handle;
    result_t          pre_r, main_r;
    logic [POS_W-1:0] pos_inc, ts_inc, ts_inc2;
    logic             is_quote, is_blank, is_redir, is_pipe;

    assign busy = in_valid_reg;

    // Capture the accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ch_reg  <= item.ch;
            eol_reg <= item.end_of_line;
        end
    end

    // Classify the byte
    always_comb
    begin
        is_quote = (ch_reg == CH_SQUOTE) || (ch_reg == CH_DQUOTE);
        is_blank = (ch_reg == CH_SPACE) || (ch_reg inside {[CH_TAB:CH_CR]});
        is_redir = (ch_reg == CH_LT) || (ch_reg == CH_GT);
        is_pipe  = (ch_reg == CH_PIPE);
        pos_inc  = sat_inc(position_reg);
        ts_inc   = sat_inc(tokens_seen_reg);
        ts_inc2  = sat_inc(ts_inc);
    end

    // Advance the line state and form the results
    always_comb
    begin
        word_active_next        = word_active_reg;
        quote_active_next       = quote_active_reg;
        quote_is_double_next    = quote_is_double_reg;
        redirect_pending_next   = redirect_pending_reg;
        redirect_is_output_next = redirect_is_output_reg;
        position_next           = position_reg;
        word_start_next         = word_start_reg;
        quote_start_next        = quote_start_reg;
        redirect_start_next     = redirect_start_reg;
        tokens_seen_next        = tokens_seen_reg;
        pre_v  = 1'b0;
        main_v = 1'b0;
        handle = 1'b0;
        pre_r  = '0;
        main_r = '0;

        if (in_valid_reg)
        begin
            if (eol_reg)
            begin
                // Flush the pending token, then close the line
                if (quote_active_reg)
                begin
                    pre_v          = 1'b1;
                    pre_r.kind     = K_QUOTED;
                    pre_r.start_pos = quote_start_reg;
                    pre_r.end_pos  = position_reg;
                end
                else if (redirect_pending_reg)
                begin
                    pre_v          = 1'b1;
                    pre_r.kind     = redirect_is_output_reg ? K_OUT : K_IN;
                    pre_r.start_pos = redirect_start_reg;
                    pre_r.end_pos  = sat_inc(redirect_start_reg);
                end
                else if (word_active_reg)
                begin
                    pre_v          = 1'b1;
                    pre_r.kind     = K_WORD;
                    pre_r.start_pos = word_start_reg;
                    pre_r.end_pos  = position_reg;
                end
                main_v             = 1'b1;
                main_r.kind        = K_END;
                main_r.start_pos   = position_reg;
                main_r.end_pos     = position_reg;
                main_r.token_count = pre_v ? ts_inc : tokens_seen_reg;
                word_active_next        = 1'b0;
                quote_active_next       = 1'b0;
                quote_is_double_next    = 1'b0;
                redirect_pending_next   = 1'b0;
                redirect_is_output_next = 1'b0;
                position_next           = '0;
                word_start_next         = '0;
                quote_start_next        = '0;
                redirect_start_next     = '0;
            end
            else if (quote_active_reg)
            begin
                // Inside a quote only the matching quote byte matters
                if (ch_reg == (quote_is_double_reg ? CH_DQUOTE : CH_SQUOTE))
                begin
                    main_v            = 1'b1;
                    main_r.kind       = K_QUOTED;
                    main_r.start_pos  = quote_start_reg;
                    main_r.end_pos    = pos_inc;
                    quote_active_next = 1'b0;
                end
                position_next = pos_inc;
            end
            else
            begin
                handle = 1'b1;
                // Resolve a held redirect: doubled or single
                if (redirect_pending_reg)
                begin
                    redirect_pending_next = 1'b0;
                    if (ch_reg == (redirect_is_output_reg ? CH_GT : CH_LT))
                    begin
                        main_v           = 1'b1;
                        main_r.kind      = redirect_is_output_reg ? K_APPEND : K_HEREDOC;
                        main_r.start_pos = redirect_start_reg;
                        main_r.end_pos   = pos_inc;
                        handle           = 1'b0;
                    end
                    else
                    begin
                        pre_v           = 1'b1;
                        pre_r.kind      = redirect_is_output_reg ? K_OUT : K_IN;
                        pre_r.start_pos = redirect_start_reg;
                        pre_r.end_pos   = sat_inc(redirect_start_reg);
                    end
                end

                if (handle)
                begin
                    // A separator ends a pending word
                    if ((is_quote || is_blank || is_redir || is_pipe) && word_active_reg)
                    begin
                        pre_v            = 1'b1;
                        pre_r.kind       = K_WORD;
                        pre_r.start_pos  = word_start_reg;
                        pre_r.end_pos    = position_reg;
                        word_active_next = 1'b0;
                    end
                    if (is_quote)
                    begin
                        quote_active_next    = 1'b1;
                        quote_is_double_next = (ch_reg == CH_DQUOTE);
                        quote_start_next     = position_reg;
                    end
                    else if (is_redir)
                    begin
                        redirect_pending_next   = 1'b1;
                        redirect_is_output_next = (ch_reg == CH_GT);
                        redirect_start_next     = position_reg;
                    end
                    else if (is_pipe)
                    begin
                        main_v           = 1'b1;
                        main_r.kind      = K_PIPE;
                        main_r.start_pos = position_reg;
                        main_r.end_pos   = pos_inc;
                    end
                    else if (!is_blank && !word_active_reg)
                    begin
                        word_active_next = 1'b1;
                        word_start_next  = position_reg;
                    end
                end
                position_next = pos_inc;
            end

            // Count tokens; the line end clears the count
            if (eol_reg)
            begin
                tokens_seen_next = '0;
            end
            else if (pre_v && main_v)
            begin
                tokens_seen_next = ts_inc2;
            end
            else if (pre_v || main_v)
            begin
                tokens_seen_next = ts_inc;
            end
        end
    end

    // Place the results in order, last flag on the final one
    always_comb
    begin
        push.v0      = pre_v || main_v;
        push.v1      = pre_v && main_v;
        push.r0      = pre_v ? pre_r : main_r;
        push.r0.last = !(pre_v && main_v);
        push.r1      = main_r;
        push.r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_active_reg        <= 1'b0;
            quote_active_reg       <= 1'b0;
            quote_is_double_reg    <= 1'b0;
            redirect_pending_reg   <= 1'b0;
            redirect_is_output_reg <= 1'b0;
            position_reg           <= '0;
            word_start_reg         <= '0;
            quote_start_reg        <= '0;
            redirect_start_reg     <= '0;
            tokens_seen_reg        <= '0;
        end
        else
        begin
            word_active_reg        <= word_active_next;
            quote_active_reg       <= quote_active_next;
            quote_is_double_reg    <= quote_is_double_next;
            redirect_pending_reg   <= redirect_pending_next;
            redirect_is_output_reg <= redirect_is_output_next;
            position_reg           <= position_next;
            word_start_reg         <= word_start_next;
            quote_start_reg        <= quote_start_next;
            redirect_start_reg     <= redirect_start_next;
            tokens_seen_reg        <= tokens_seen_next;
        end
    end

    `SCLT_ASSERT(a_second_needs_first, push.v1 |-> push.v0, "second result without first")
    `SCLT_ASSERT(a_end_is_last,
        (in_valid_reg && eol_reg) |->
            ((push.v1 && push.r1.kind == K_END) || (!push.v1 && push.r0.kind == K_END)),
        "line end descriptor not in final slot")
    `SCLT_ASSERT(a_line_cleared,
        (in_valid_reg && eol_reg) |=>
            (position_reg == '0 && tokens_seen_reg == '0 && !word_active_reg
             && !quote_active_reg && !redirect_pending_reg),
        "line state not cleared after line end")
    `SCLT_ASSERT(a_pos_capped, position_reg <= POS_CAP, "position beyond cap")

endmodule

### rtl/sclt_out_queue.sv
`timescale 1ns / 1ps

module sclt_out_queue
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  sclt_pkg::push_t           push,
    output logic [sclt_pkg::FIFO_CW-1:0] count,
    output logic                      m_valid,
    input  logic                      m_ready,
    output sclt_pkg::result_t         m_item
);
    import sclt_pkg::*;

`include "shell_command_line_tokenizer_assert.svh"

    result_t              mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0]   count_reg, count_next;
    logic                 pop;
    logic [FIFO_CW-1:0]   n_push;

    assign m_valid = (count_reg != '0);
    assign m_item  = mem_reg[rd_ptr_reg];
    assign count   = count_reg;
    assign pop     = m_valid && m_ready;

    // Advance pointers and fill level
    always_comb
    begin
        n_push      = FIFO_CW'(push.v0) + FIFO_CW'(push.v1);
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(n_push);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + n_push - FIFO_CW'(pop);
    end

    // Store results in arrival order
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem_reg[wr_ptr_reg + FIFO_AW'(1)] <= push.r1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SCLT_ASSERT(a_room_on_push, push.v0 |-> (count_reg <= FIFO_CW'(FIFO_DEPTH - 2)),
        "result queue overflow")
    `SCLT_ASSERT(a_pop_only,
        (pop && !push.v0) |=> (count_reg == $past(count_reg) - FIFO_CW'(1)),
        "fill level wrong after drain")
    `SCLT_ASSERT(a_ptr_gap,
        (count_reg < FIFO_CW'(FIFO_DEPTH)) |->
            (FIFO_AW'(wr_ptr_reg - rd_ptr_reg) == FIFO_AW'(count_reg)),
        "pointers disagree with fill level")

endmodule

### rtl/shell_command_line_tokenizer.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields (tdata from bit 0 up)                           tlast
// s_axis   in   tdata[7:0] ch                                           end_of_line
// m_axis   out  tdata[2:0] kind, [15:3] start_pos, [28:16] end_pos,     last
//               [41:29] token_count, [47:42] zero
//
// One byte is taken per cycle while s_tready is high; each byte yields zero, one
// or two descriptors, and one descriptor leaves per cycle while m_tready is high.
// The limit is the output channel: a byte producing two descriptors takes two
// output transfers, drained from an eight-entry result queue.
// s_tready drops when the queue cannot take the worst case of two descriptors
// for the byte in flight and for a new byte, so a stalled master stalls input.
// rst_n clears the line state and empties the queue; no clearing pass.

module shell_command_line_tokenizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // end_of_line
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [2:0] kind, [15:3] start_pos, [28:16] end_pos,
                                   // [41:29] token_count, [47:42] zero
    output logic        m_tlast    // last
);
    import sclt_pkg::*;

    in_item_t           item;
    push_t              push;
    result_t            res;
    logic               accept;
    logic               busy;
    logic [FIFO_CW-1:0] count;
    logic [FIFO_CW:0]   reserved;

    // Accept while the queue has room for everything in flight
    assign reserved = {1'b0, count} + (busy ? (FIFO_CW+1)'(2) : '0);
    assign s_tready = (reserved <= (FIFO_CW+1)'(FIFO_DEPTH - 2));
    assign accept   = s_tvalid && s_tready;

    assign item.ch          = s_tdata;
    assign item.end_of_line = s_tlast;

    sclt_lexer u_lexer
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .push   (push),
        .busy   (busy)
    );

    sclt_out_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .count   (count),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_item  (res)
    );

    // Pack the descriptor
    assign m_tdata = {6'd0, res.token_count, res.end_pos, res.start_pos, res.kind};
    assign m_tlast = res.last;

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import sclt_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int FLOOD_LEN    = 300;
    localparam int DRAIN_CYCLES = 24;

    typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_BURSTY} rx_mode_t;

    // Token predictor and store of expected descriptors
    class token_scoreboard;
        result_t          expected_q[$];
        result_t          step_q[$];
        int unsigned      mismatches;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] word_start;
        logic [POS_W-1:0] quote_start;
        logic [POS_W-1:0] redir_start;
        logic [POS_W-1:0] tokens;
        logic             word_on;
        logic             quote_on;
        logic             quote_dq;
        logic             redir_on;
        logic             redir_out;

        function new();
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            pos         = '0;
            word_start  = '0;
            quote_start = '0;
            redir_start = '0;
            tokens      = '0;
            word_on     = 1'b0;
            quote_on    = 1'b0;
            quote_dq    = 1'b0;
            redir_on    = 1'b0;
            redir_out   = 1'b0;
        endfunction

        // Step a position by one, holding at the cap
        function logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] v);
            if (v < POS_CAP)
                return v + 1'b1;
            return POS_CAP;
        endfunction

        function void push_desc(input kind_t k, input logic [POS_W-1:0] s,
                                input logic [POS_W-1:0] e, input logic [POS_W-1:0] cnt);
            result_t r;
            r.kind        = k;
            r.start_pos   = s;
            r.end_pos     = e;
            r.token_count = cnt;
            r.last        = 1'b0;
            step_q.push_back(r);
        endfunction

        function void add_token(input kind_t k, input logic [POS_W-1:0] s,
                                input logic [POS_W-1:0] e);
            push_desc(k, s, e, '0);
            tokens = next_pos(tokens);
        endfunction

        function void close_word();
            if (word_on)
            begin
                add_token(K_WORD, word_start, pos);
                word_on = 1'b0;
            end
        endfunction

        // Handle one byte outside quotes with no redirect held
        function void take_byte(input logic [7:0] c);
            if (c == CH_SQUOTE || c == CH_DQUOTE)
            begin
                close_word();
                quote_on    = 1'b1;
                quote_dq    = (c == CH_DQUOTE);
                quote_start = pos;
            end
            else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            begin
                close_word();
            end
            else if (c == CH_LT || c == CH_GT)
            begin
                close_word();
                redir_on    = 1'b1;
                redir_out   = (c == CH_GT);
                redir_start = pos;
            end
            else if (c == CH_PIPE)
            begin
                close_word();
                add_token(K_PIPE, pos, next_pos(pos));
            end
            else if (!word_on)
            begin
                word_on    = 1'b1;
                word_start = pos;
            end
        endfunction

        // Predict the descriptors of one accepted input transfer
        function void note_input(input logic [7:0] c, input logic eol);
            step_q.delete();
            if (eol)
            begin
                if (quote_on)
                    add_token(K_QUOTED, quote_start, pos);
                else if (redir_on)
                    add_token(redir_out ? K_OUT : K_IN, redir_start, next_pos(redir_start));
                else
                    close_word();
                push_desc(K_END, pos, pos, tokens);
                clear_line();
            end
            else if (quote_on)
            begin
                if (c == (quote_dq ? CH_DQUOTE : CH_SQUOTE))
                begin
                    add_token(K_QUOTED, quote_start, next_pos(pos));
                    quote_on = 1'b0;
                end
                pos = next_pos(pos);
            end
            else
            begin
                if (redir_on)
                begin
                    redir_on = 1'b0;
                    if (c == (redir_out ? CH_GT : CH_LT))
                    begin
                        add_token(redir_out ? K_APPEND : K_HEREDOC, redir_start, next_pos(pos));
                    end
                    else
                    begin
                        add_token(redir_out ? K_OUT : K_IN, redir_start, next_pos(redir_start));
                        take_byte(c);
                    end
                end
                else
                begin
                    take_byte(c);
                end
                pos = next_pos(pos);
            end
            if (step_q.size() > 0)
                step_q[step_q.size()-1].last = 1'b1;
            foreach (step_q[i])
                expected_q.push_back(step_q[i]);
        endfunction

        // Compare one output transfer with the oldest expected descriptor
        function void check_result(input logic [47:0] data, input logic last_bit);
            result_t got;
            result_t want;
            got.kind        = kind_t'(data[2:0]);
            got.start_pos   = data[15:3];
            got.end_pos     = data[28:16];
            got.token_count = data[41:29];
            got.last        = last_bit;
            if (expected_q.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected descriptor: kind=%0d start=%0d end=%0d count=%0d last=%0d",
                             got.kind, got.start_pos, got.end_pos, got.token_count, got.last);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got !== want || data[47:42] !== 6'd0)
            begin
                if (mismatches < 10)
                    $display({"mismatch: expected kind=%0d start=%0d end=%0d count=%0d last=%0d",
                              " got kind=%0d start=%0d end=%0d count=%0d last=%0d pad=%h"},
                             want.kind, want.start_pos, want.end_pos, want.token_count, want.last,
                             got.kind, got.start_pos, got.end_pos, got.token_count, got.last,
                             data[47:42]);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic        m_tlast;

    token_scoreboard sb = new();
    int          cycles      = 0;
    int          items_sent  = 0;
    int          burst_left  = 0;

    // Directed line set: {end_of_line, ch}
    logic [8:0] directed_items [0:25] = '{
        {1'b0, "a"}, {1'b0, 8'h00}, {1'b0, CH_SQUOTE}, {1'b0, CH_DQUOTE}, {1'b0, CH_SQUOTE},
        {1'b0, CH_GT}, {1'b0, CH_PIPE}, {1'b0, CH_LT}, {1'b0, CH_LT}, {1'b0, CH_GT},
        {1'b0, CH_GT}, {1'b0, CH_TAB}, {1'b0, 8'hFF}, {1'b0, CH_DQUOTE}, {1'b0, "q"},
        {1'b1, 8'hFF},
        {1'b0, CH_LT}, {1'b1, 8'h00},
        {1'b1, 8'hA5},
        {1'b0, CH_GT}, {1'b0, "x"}, {1'b0, CH_CR}, {1'b0, "b"}, {1'b0, CH_LT},
        {1'b0, CH_SQUOTE}, {1'b1, 8'h5A}
    };

    shell_command_line_tokenizer uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Observe both channels on pre-edge values
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
            sb.note_input(s_tdata, s_tlast);
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
    end

    // Drive output backpressure from a changing stall pattern
    rx_mode_t rx_mode     = RX_OPEN;
    int       rx_left     = 0;
    int       rx_phase    = 0;
    int       stall_left  = 0;

    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 300);
        end
        else
        begin
            rx_left--;
        end
        rx_phase++;
        case (rx_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= $urandom_range(0, 1);
            RX_PERIODIC: m_tready <= (rx_phase % 5) < 3;
            default:
            begin
                if (stall_left > 0)
                begin
                    stall_left--;
                    m_tready <= 1'b0;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    stall_left = $urandom_range(1, 20);
                    m_tready <= 1'b0;
                end
                else
                begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    // Present one item and hold it until the transfer; may idle between bursts
    task automatic send_item(input logic [7:0] c, input logic eol);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 60);
            gap = $urandom_range(0, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eol;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_blank();
        int sel;
        sel = $urandom_range(0, 5);
        send_item((sel == 0) ? CH_SPACE : CH_TAB + 8'(sel - 1), 1'b0);
    endtask

    initial
    begin
        int         sel;
        int         len;
        int         pieces;
        int         target;
        logic [7:0] q;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed lines: every kind, doubling, flush cases, extreme bytes
        foreach (directed_items[i])
            send_item(directed_items[i][7:0], directed_items[i][8]);

        // One long line, mostly pipes, to build up positions and the count
        for (int i = 0; i < FLOOD_LEN; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 85)
                send_item(CH_PIPE, 1'b0);
            else if (sel < 95)
                send_item(8'("a" + $urandom_range(0, 25)), 1'b0);
            else if (sel < 98)
                send_item(CH_LT, 1'b0);
            else
                send_item(CH_GT, 1'b0);
        end
        send_item(CH_SQUOTE, 1'b0);
        send_item("x", 1'b0);
        send_item(CH_SQUOTE, 1'b0);
        send_item(CH_GT, 1'b0);
        send_item("y", 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);

        // Random command lines built from tokens, with raw noise mixed in
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target)
        begin
            pieces = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 30) : $urandom_range(0, 8);
            for (int p = 0; p < pieces; p++)
            begin
                sel = $urandom_range(0, 99);
                if (sel < 35)
                begin
                    len = $urandom_range(1, 6);
                    for (int k = 0; k < len; k++)
                    begin
                        if ($urandom_range(0, 4) == 0)
                            send_item(8'($urandom_range(0, 255)), 1'b0);
                        else
                            send_item(8'("a" + $urandom_range(0, 25)), 1'b0);
                    end
                end
                else if (sel < 50)
                begin
                    q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
                    send_item(q, 1'b0);
                    len = $urandom_range(0, 5);
                    for (int k = 0; k < len; k++)
                        send_item(8'($urandom_range(0, 255)), 1'b0);
                    if ($urandom_range(0, 9) != 0)
                        send_item(q, 1'b0);
                end
                else if (sel < 60)
                begin
                    q = $urandom_range(0, 1) ? CH_GT : CH_LT;
                    send_item(q, 1'b0);
                    if ($urandom_range(0, 1))
                        send_item(q, 1'b0);
                end
                else if (sel < 68)
                begin
                    send_item(CH_PIPE, 1'b0);
                end
                else if (sel < 80)
                begin
                    send_blank();
                end
                else
                begin
                    send_item(8'($urandom_range(0, 255)), 1'b0);
                end
                if ($urandom_range(0, 9) < 6)
                    send_blank();
            end
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        s_tvalid <= 1'b0;

        // Let the monitor note the last transfer, drain, then allow for the pipeline
        @(posedge clk);
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/sclt_pkg.sv
rtl/sclt_lexer.sv
rtl/sclt_out_queue.sv
rtl/shell_command_line_tokenizer.sv
verif/testbench.sv
